// ===== design/dcg_pkg.sv =====
// ---------------------------------------------------------------------------
// dcg_pkg
// Shared types and constants for the connected group tracker.
// ---------------------------------------------------------------------------
package dcg_pkg;

   localparam int UNITS = 64;               // number of tracked units
   localparam int UW    = 6;                // unit index width
   localparam int RW    = 8;                // edge reference count width
   localparam int GW    = 16;               // group identifier width
   localparam int EW    = 2 * UW;           // edge matrix address width
   localparam int CW    = UW + 1;           // counter width, holds UNITS itself

   localparam logic [RW-1:0] REF_MAX = '1;
   localparam logic [GW-1:0] GID_MAX = '1;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_REM   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_DONE   = 2'd0,
      STS_SELF   = 2'd1,
      STS_ABSENT = 2'd2,
      STS_SPARE  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_WR1, ST_WR2,
      ST_NEW1, ST_NEW2, ST_SET_S, ST_SET_T, ST_COUNT, ST_REWRITE,
      ST_BFS_INIT, ST_BFS_POP, ST_BFS_CUR, ST_BFS_ROW,
      ST_ORPH, ST_SCAN, ST_ASSIGN, ST_REP0, ST_REP1, ST_REP2, ST_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]    cmd;
      logic [UW-1:0] subject_unit;
      logic [UW-1:0] target_unit;
   } req_type;

   typedef struct packed {
      logic [GW-1:0] subject_group;
      logic [GW-1:0] target_group;
      logic [CW-1:0] groups_created;
      logic [1:0]    status;
   } rsp_type;

endpackage

// ===== design/dcg_ram.sv =====
// ---------------------------------------------------------------------------
// dcg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module dcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dynamic_connected_group_tracker_unit.sv =====
// ---------------------------------------------------------------------------
// dynamic_connected_group_tracker_unit
// Tracks connected groups of units under edge add, remove and query words.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one word {cmd, subject_unit, target_unit} per command.
//   rsp channel: exactly one word per command with both units' groups after
//   the command, the number of fresh groups and a status code.
//   One command is worked at a time by a sequencer that drives three RAMs
//   (edge counts, group ids, search queue) one access per cycle.
//   A merge of two groups on add takes a count sweep and a rewrite sweep.
//   Removal of the last reference runs a member count sweep, then either
//   a rewrite sweep or searches that read the edge RAM row of each unit
//   visited through its read port.
//   Reset: synchronous; afterwards a clearing pass writes the 4096-entry
//   edge RAM, one entry a cycle, so req_ready stays low until it ends.
//   Stall: a finished result waits in the rsp output register; the next
//   req word is taken meanwhile and its result waits in its final state
//   until the register frees.
// ---------------------------------------------------------------------------
module dynamic_connected_group_tracker_unit
   import dcg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // sequencer state
   state_type     state_ff, state_in;
   logic [EW-1:0] clr_ff, clr_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [UW-1:0] s_ff, s_in, t_ff, t_in;
   logic [GW-1:0] gid_ff, gid_in;
   logic [UNITS-1:0] gvalid_ff, gvalid_in;
   logic             gvld_rd_ff;
   logic [UNITS-1:0] visited_ff, visited_in;
   logic [UNITS-1:0] orphan_ff, orphan_in;
   logic [RW-1:0] ref_ff, ref_in, wval_ff, wval_in;
   logic          wen_ff, wen_in;
   logic [GW-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic [GW-1:0] from_ff, from_in, to_ff, to_in, newid_ff, newid_in;
   logic [CW-1:0] ca_ff, ca_in, cb_ff, cb_in, reach_ff, reach_in;
   logic [CW-1:0] cnt_ff, cnt_in, scan_ff, scan_in;
   logic [CW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic          pend_ff, pend_in;
   logic [UW-1:0] pidx_ff, pidx_in, cur_ff, cur_in, start_ff, start_in;
   logic          sub_ff, sub_in;
   logic [CW-1:0] created_ff, created_in;
   logic [1:0]    status_ff, status_in;
   logic [GW-1:0] subj_ff, subj_in, targ_ff, targ_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // RAM ports
   logic          e_we, g_we, q_we;
   logic [EW-1:0] e_waddr, e_raddr;
   logic [RW-1:0] e_wdata, e_rdata;
   logic [UW-1:0] g_waddr, g_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
   logic [GW-1:0] g_wdata, g_rdata, gval;
   logic [GW-1:0] gid_next;
   logic          sweep_done, load;

   dcg_ram #(.WIDTH(RW), .DEPTH(UNITS * UNITS)) u_edge_ram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
      .rd_addr(e_raddr), .rd_data(e_rdata));

   dcg_ram #(.WIDTH(GW), .DEPTH(UNITS)) u_group_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
      .rd_addr(g_raddr), .rd_data(g_rdata));

   dcg_ram #(.WIDTH(UW), .DEPTH(UNITS)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   // never-written group entries read as no group
   assign gval       = gvld_rd_ff ? g_rdata : '0;
   assign gid_next   = (gid_ff == GID_MAX) ? GW'(1) : gid_ff + GW'(1);
   assign sweep_done = cnt_ff[UW] && !pend_ff;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         gid_ff       <= GW'(1);
         gvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gid_ff       <= gid_in;
         gvalid_ff    <= gvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      gvld_rd_ff  <= gvalid_ff[g_raddr];
      cmd_ff      <= cmd_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      visited_ff  <= visited_in;
      orphan_ff   <= orphan_in;
      ref_ff      <= ref_in;
      wval_ff     <= wval_in;
      wen_ff      <= wen_in;
      ga_ff       <= ga_in;
      gb_ff       <= gb_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      newid_ff    <= newid_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      reach_ff    <= reach_in;
      cnt_ff      <= cnt_in;
      scan_ff     <= scan_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      pidx_ff     <= pidx_in;
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      sub_ff      <= sub_in;
      created_ff  <= created_in;
      status_ff   <= status_in;
      subj_ff     <= subj_in;
      targ_ff     <= targ_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      s_in       = s_ff;
      t_in       = t_ff;
      gid_in     = gid_ff;
      gvalid_in  = gvalid_ff;
      visited_in = visited_ff;
      orphan_in  = orphan_ff;
      ref_in     = ref_ff;
      wval_in    = wval_ff;
      wen_in     = wen_ff;
      ga_in      = ga_ff;
      gb_in      = gb_ff;
      from_in    = from_ff;
      to_in      = to_ff;
      newid_in   = newid_ff;
      ca_in      = ca_ff;
      cb_in      = cb_ff;
      reach_in   = reach_ff;
      cnt_in     = cnt_ff;
      scan_in    = scan_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      pend_in    = 1'b0;
      pidx_in    = pidx_ff;
      cur_in     = cur_ff;
      start_in   = start_ff;
      sub_in     = sub_ff;
      created_in = created_ff;
      status_in  = status_ff;
      subj_in    = subj_ff;
      targ_in    = targ_ff;
      e_we       = 1'b0;
      e_waddr    = {s_ff, t_ff};
      e_wdata    = wval_ff;
      e_raddr    = {s_ff, t_ff};
      g_we       = 1'b0;
      g_waddr    = s_ff;
      g_wdata    = '0;
      g_raddr    = s_ff;
      q_we       = 1'b0;
      q_waddr    = tail_ff[UW-1:0];
      q_wdata    = pidx_ff;
      q_raddr    = head_ff[UW-1:0];
      load       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            e_wdata = '0;
            clr_in  = clr_ff + EW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data.cmd;
               s_in       = req_data.subject_unit;
               t_in       = req_data.target_unit;
               created_in = '0;
               status_in  = STS_DONE;
               e_raddr    = {req_data.subject_unit, req_data.target_unit};
               g_raddr    = req_data.subject_unit;
               if (req_data.cmd == CMD_ADD || req_data.cmd == CMD_REM) begin
                  if (req_data.subject_unit != req_data.target_unit) begin
                     state_in = ST_RD1;
                  end else begin
                     status_in = STS_SELF;
                     state_in  = ST_REP0;
                  end
               end else begin
                  state_in = ST_REP0;
               end
            end
         end
         ST_RD1: begin
            ref_in   = e_rdata;
            ga_in    = gval;
            g_raddr  = t_ff;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            gb_in = gval;
            if (cmd_ff == CMD_ADD) begin
               wen_in   = (ref_ff != REF_MAX);
               wval_in  = ref_ff + RW'(1);
               state_in = ST_WR1;
            end else if (ref_ff == '0) begin
               status_in = STS_ABSENT;
               state_in  = ST_REP0;
            end else begin
               wen_in   = 1'b1;
               wval_in  = ref_ff - RW'(1);
               state_in = ST_WR1;
            end
         end
         ST_WR1: begin
            e_we     = wen_ff;
            state_in = ST_WR2;
         end
         ST_WR2: begin
            // mirror entry keeps the matrix symmetric
            e_we    = wen_ff;
            e_waddr = {t_ff, s_ff};
            cnt_in  = '0;
            ca_in   = '0;
            cb_in   = '0;
            if (cmd_ff == CMD_ADD) begin
               priority if (ga_ff == '0 && gb_ff == '0) begin
                  state_in = ST_NEW1;
               end else if (gb_ff == '0) begin
                  state_in = ST_SET_T;
               end else if (ga_ff == '0) begin
                  state_in = ST_SET_S;
               end else if (ga_ff != gb_ff) begin
                  state_in = ST_COUNT;
               end else begin
                  state_in = ST_REP0;
               end
            end else if (wval_ff == '0 && ga_ff != '0) begin
               state_in = ST_COUNT;
            end else begin
               state_in = ST_REP0;
            end
         end
         ST_NEW1: begin
            g_we     = 1'b1;
            g_wdata  = gid_ff;
            state_in = ST_NEW2;
         end
         ST_NEW2: begin
            g_we       = 1'b1;
            g_waddr    = t_ff;
            g_wdata    = gid_ff;
            gid_in     = gid_next;
            created_in = CW'(1);
            state_in   = ST_REP0;
         end
         ST_SET_T: begin
            g_we     = 1'b1;
            g_waddr  = t_ff;
            g_wdata  = ga_ff;
            state_in = ST_REP0;
         end
         ST_SET_S: begin
            g_we     = 1'b1;
            g_wdata  = gb_ff;
            state_in = ST_REP0;
         end
         ST_COUNT: begin
            // member count of both groups, one entry a cycle
            g_raddr = cnt_ff[UW-1:0];
            pend_in = !cnt_ff[UW];
            pidx_in = cnt_ff[UW-1:0];
            cnt_in  = cnt_ff + CW'(!cnt_ff[UW]);
            if (pend_ff && gval == ga_ff) begin
               ca_in = ca_ff + CW'(1);
            end
            if (pend_ff && gval == gb_ff) begin
               cb_in = cb_ff + CW'(1);
            end
            if (sweep_done) begin
               cnt_in = '0;
               if (cmd_ff == CMD_ADD) begin
                  // larger group keeps its id, subject wins a tie
                  from_in  = (ca_ff < cb_ff) ? ga_ff : gb_ff;
                  to_in    = (ca_ff < cb_ff) ? gb_ff : ga_ff;
                  state_in = ST_REWRITE;
               end else if (ca_ff <= CW'(1)) begin
                  from_in  = ga_ff;
                  to_in    = '0;
                  state_in = ST_REWRITE;
               end else begin
                  start_in = s_ff;
                  sub_in   = 1'b0;
                  state_in = ST_BFS_INIT;
               end
            end
         end
         ST_REWRITE: begin
            g_raddr = cnt_ff[UW-1:0];
            pend_in = !cnt_ff[UW];
            pidx_in = cnt_ff[UW-1:0];
            cnt_in  = cnt_ff + CW'(!cnt_ff[UW]);
            g_waddr = pidx_ff;
            g_wdata = to_ff;
            g_we    = pend_ff && (gval == from_ff);
            if (sweep_done) begin
               state_in = ST_REP0;
            end
         end
         ST_BFS_INIT: begin
            visited_in = {{(UNITS-1){1'b0}}, 1'b1} << start_ff;
            q_we       = 1'b1;
            q_waddr    = '0;
            q_wdata    = start_ff;
            head_in    = '0;
            tail_in    = CW'(1);
            reach_in   = CW'(1);
            state_in   = ST_BFS_POP;
         end
         ST_BFS_POP: begin
            if (head_ff == tail_ff) begin
               cnt_in = '0;
               if (!sub_ff) begin
                  state_in = (reach_ff == ca_ff) ? ST_REP0 : ST_ORPH;
               end else begin
                  newid_in   = gid_ff;
                  gid_in     = gid_next;
                  created_in = created_ff + CW'(1);
                  state_in   = ST_ASSIGN;
               end
            end else begin
               head_in  = head_ff + CW'(1);
               state_in = ST_BFS_CUR;
            end
         end
         ST_BFS_CUR: begin
            cur_in   = q_rdata;
            cnt_in   = '0;
            state_in = ST_BFS_ROW;
         end
         ST_BFS_ROW: begin
            // adjacency row walk of the current unit
            e_raddr = {cur_ff, cnt_ff[UW-1:0]};
            pend_in = !cnt_ff[UW];
            pidx_in = cnt_ff[UW-1:0];
            cnt_in  = cnt_ff + CW'(!cnt_ff[UW]);
            if (pend_ff && e_rdata != '0 && !visited_ff[pidx_ff]) begin
               visited_in[pidx_ff] = 1'b1;
               reach_in            = reach_ff + CW'(1);
               if (!tail_ff[UW]) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + CW'(1);
               end
            end
            if (sweep_done) begin
               state_in = ST_BFS_POP;
            end
         end
         ST_ORPH: begin
            g_raddr = cnt_ff[UW-1:0];
            pend_in = !cnt_ff[UW];
            pidx_in = cnt_ff[UW-1:0];
            cnt_in  = cnt_ff + CW'(!cnt_ff[UW]);
            if (pend_ff) begin
               orphan_in[pidx_ff] = (gval == ga_ff) && !visited_ff[pidx_ff];
            end
            if (sweep_done) begin
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // lowest remaining orphan seeds the next cluster
            if (scan_ff[UW]) begin
               state_in = ST_REP0;
            end else if (orphan_ff[scan_ff[UW-1:0]]) begin
               start_in = scan_ff[UW-1:0];
               sub_in   = 1'b1;
               state_in = ST_BFS_INIT;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_ASSIGN: begin
            g_waddr = cnt_ff[UW-1:0];
            g_wdata = newid_ff;
            g_we    = !cnt_ff[UW] && visited_ff[cnt_ff[UW-1:0]];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff[UW]) begin
               orphan_in = orphan_ff & ~visited_ff;
               state_in  = ST_SCAN;
            end
         end
         ST_REP0: begin
            state_in = ST_REP1;
         end
         ST_REP1: begin
            subj_in  = gval;
            g_raddr  = t_ff;
            state_in = ST_REP2;
         end
         ST_REP2: begin
            targ_in  = gval;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (g_we) begin
         gvalid_in[g_waddr] = 1'b1;
      end

      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_data_in.subject_group  = subj_ff;
         rsp_data_in.target_group   = targ_ff;
         rsp_data_in.groups_created = created_ff;
         rsp_data_in.status         = status_ff;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

`ifndef SYNTHESIS
   a_gid_nonzero: assert property (@(posedge clock) disable iff (reset)
      gid_ff != '0) else $error("group id counter reached zero");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BFS_POP || state_ff == ST_BFS_ROW) |-> head_ff <= tail_ff)
      else $error("search queue head passed tail");

   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready))
      |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("finished word not loaded");
`endif

endmodule
